// ===== rtl/periodic_timer_table_macros.svh =====
// ----------------------------------------------------------------------------
// Periodic timer table assertion macros
// Shared concurrent-assertion wrappers, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TIMER_TABLE_MACROS_SVH

// Same-cycle implication.
`define PTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptt_pkg
// Types, codes and sizes shared by the periodic timer table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

  localparam int TIMER_SLOTS   = 16;
  localparam int SLOT_W        = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int OUT_SLOT_W    = 4;
  localparam int ELAP_W        = 32;
  localparam int STEP_W        = 8;
  localparam logic [STEP_W-1:0] TICK_STEP_RESET = 8'd10;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_CREATE = 2'd1,
    OP_DELETE = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_FIRE   = 2'd1,
    KIND_DONE   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_TIMER = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_EVAL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ELAP_W-1:0] period;
    logic [7:0]        device;
    logic [15:0]       command;
    logic              notify;
  } slot_cfg_t;

  typedef struct packed {
    logic              rd_en;
    logic              cfg_we;
    logic              elap_we;
    logic [SLOT_W-1:0] addr;
  } store_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/periodic_timer_table.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_table
// Table of periodic timers: create, delete and tick commands in, status,
// fire events and tick-done beats out.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Content
//  in_*      in_valid / in_ready    opcode, slot, period, device, command, notify
//  out_*     out_valid / out_ready  kind, status, slot, device, command, last
//  cfg_*     cfg_wr_en              tick_step (8 bit)
//
//  Create and delete commands produce a status beat that is registered and
//  shows the next cycle; ignored opcodes produce no beat.
//  A tick walks the slots through the single storage port: a free slot is
//  skipped in S_RD, a live one is read in S_RD, then evaluated and written
//  back in S_EVAL; S_DONE then issues the done beat.
//  A stalled output holds the walk at the firing slot; input waits until idle.
//  Reset (synchronous, active low) clears all slots and sets tick_step to 10.
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_timer_table_macros.svh"

module periodic_timer_table
  import ptt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [3:0]  in_slot_index,
  input  wire logic [31:0] in_period,
  input  wire logic [7:0]  in_target_device,
  input  wire logic [15:0] in_action_code,
  input  wire logic        in_notify,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [1:0]       out_status,
  output logic [3:0]       out_slot_out,
  output logic [7:0]       out_fire_device,
  output logic [15:0]      out_fire_command,
  output logic             out_last,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);

  state_t                  state_r, state_nxt;
  logic [SLOT_W-1:0]       ptr_r, ptr_nxt;
  logic [TIMER_SLOTS-1:0]  valid_r, valid_nxt;
  logic [STEP_W-1:0]       tick_step_r;

  logic                    out_valid_r;
  kind_t                   out_kind_r;
  status_t                 out_status_r;
  logic [OUT_SLOT_W-1:0]   out_slot_r;
  logic [7:0]              out_dev_r;
  logic [15:0]             out_cmd_r;
  logic                    out_last_r;

  logic                    out_load;
  kind_t                   o_kind;
  status_t                 o_status;
  logic [OUT_SLOT_W-1:0]   o_slot;
  logic [7:0]              o_dev;
  logic [15:0]             o_cmd;
  logic                    o_last;

  store_ctl_t              ctl;
  logic [ELAP_W-1:0]       elap_wdata;
  slot_cfg_t               cfg_wdata;
  logic [ELAP_W-1:0]       rd_elapsed;
  slot_cfg_t               rd_cfg;

  logic                    out_free;
  logic                    in_fire;
  op_t                     op;
  logic                    free_found;
  logic [SLOT_W-1:0]       free_idx;
  logic [SLOT_W-1:0]       del_idx;
  logic                    del_hit;
  logic                    ptr_last;
  logic [ELAP_W:0]         sum_w;
  logic [ELAP_W-1:0]       sum_sat;
  logic                    expired;
  logic                    need_out;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;
  assign op       = op_t'(in_opcode);
  assign ptr_last = (ptr_r == SLOT_W'(TIMER_SLOTS - 1));

  assign del_idx  = SLOT_W'(in_slot_index);
  assign del_hit  = (32'(in_slot_index) < TIMER_SLOTS) && valid_r[del_idx];

  assign cfg_wdata = '{period: in_period, device: in_target_device,
                       command: in_action_code, notify: in_notify};

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // Saturating advance and expiry test on the slot just read.
  assign sum_w    = {1'b0, rd_elapsed} + (ELAP_W + 1)'(tick_step_r);
  assign sum_sat  = sum_w[ELAP_W] ? '1 : sum_w[ELAP_W-1:0];
  assign expired  = (sum_sat >= rd_cfg.period);
  assign need_out = expired && rd_cfg.notify;

  ptt_store u_store (
    .clk        (clk),
    .ctl        (ctl),
    .elap_wdata (elap_wdata),
    .cfg_wdata  (cfg_wdata),
    .rd_elapsed (rd_elapsed),
    .rd_cfg     (rd_cfg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      valid_r     <= '0;
      tick_step_r <= TICK_STEP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      valid_r <= valid_nxt;
      if (cfg_wr_en) begin
        tick_step_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r   <= o_kind;
      out_status_r <= o_status;
      out_slot_r   <= o_slot;
      out_dev_r    <= o_dev;
      out_cmd_r    <= o_cmd;
      out_last_r   <= o_last;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    ptr_nxt     = ptr_r;
    valid_nxt   = valid_r;
    ctl         = '0;
    elap_wdata  = '0;
    out_load    = 1'b0;
    o_kind      = KIND_STATUS;
    o_status    = ST_OK;
    o_slot      = '0;
    o_dev       = '0;
    o_cmd       = '0;
    o_last      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (op)
            OP_TICK: begin
              ptr_nxt   = '0;
              state_nxt = S_RD;
            end
            OP_CREATE: begin
              out_load = 1'b1;
              o_last   = 1'b1;
              if (free_found) begin
                valid_nxt[free_idx] = 1'b1;
                ctl.addr    = free_idx;
                ctl.cfg_we  = 1'b1;
                ctl.elap_we = 1'b1;
                o_slot      = OUT_SLOT_W'(free_idx);
              end else begin
                o_status = ST_FULL;
              end
            end
            OP_DELETE: begin
              out_load = 1'b1;
              o_last   = 1'b1;
              o_slot   = in_slot_index;
              if (del_hit) begin
                valid_nxt[del_idx] = 1'b0;
              end else begin
                o_status = ST_NO_TIMER;
              end
            end
            OP_RSVD: begin
              // drop the beat
            end
          endcase
        end
      end
      S_RD: begin
        if (valid_r[ptr_r]) begin
          ctl.rd_en = 1'b1;
          ctl.addr  = ptr_r;
          state_nxt = S_EVAL;
        end else if (ptr_last) begin
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_EVAL: begin
        // hold here while a fire beat cannot be placed
        if (!need_out || out_free) begin
          ctl.elap_we = 1'b1;
          ctl.addr    = ptr_r;
          elap_wdata  = expired ? '0 : sum_sat;
          if (need_out) begin
            out_load = 1'b1;
            o_kind   = KIND_FIRE;
            o_slot   = OUT_SLOT_W'(ptr_r);
            o_dev    = rd_cfg.device;
            o_cmd    = rd_cfg.command;
          end
          if (ptr_last) begin
            state_nxt = S_DONE;
          end else begin
            ptr_nxt   = ptr_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          o_kind    = KIND_DONE;
          o_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_status       = out_status_r;
  assign out_slot_out     = out_slot_r;
  assign out_fire_device  = out_dev_r;
  assign out_fire_command = out_cmd_r;
  assign out_last         = out_last_r;

  `PTT_ASSERT_NOW(a_tick_wb_live, ctl.elap_we && !ctl.cfg_we, valid_r[ctl.addr], "tick wrote back a free slot")
  `PTT_ASSERT_NEXT(a_tick_starts, in_fire && (op == OP_TICK), state_r == S_RD, "tick did not start walk")
  `PTT_ASSERT_NOW(a_eval_after_rd, state_r == S_EVAL, $past(state_r) == S_RD || $past(state_r) == S_EVAL, "evaluate without read")
  `PTT_ASSERT_NOW(a_load_free, out_load, !out_valid_r || out_ready, "output overwritten while stalled")

endmodule

`default_nettype wire

// ===== rtl/ptt_store.sv =====
// ----------------------------------------------------------------------------
// ptt_store
// Per-slot timer storage: elapsed counts and timer settings, one shared
// address, registered read data held until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_store
  import ptt_pkg::*;
(
  input  wire logic              clk,
  input  wire store_ctl_t        ctl,
  input  wire logic [ELAP_W-1:0] elap_wdata,
  input  wire slot_cfg_t         cfg_wdata,
  output logic      [ELAP_W-1:0] rd_elapsed,
  output slot_cfg_t              rd_cfg
);

  logic [ELAP_W-1:0] elap_mem [TIMER_SLOTS];
  slot_cfg_t         cfg_mem  [TIMER_SLOTS];

  always_ff @(posedge clk) begin
    if (ctl.elap_we) begin
      elap_mem[ctl.addr] <= elap_wdata;
    end
    if (ctl.rd_en) begin
      rd_elapsed <= elap_mem[ctl.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cfg_we) begin
      cfg_mem[ctl.addr] <= cfg_wdata;
    end
    if (ctl.rd_en) begin
      rd_cfg <= cfg_mem[ctl.addr];
    end
  end

endmodule

`default_nettype wire
